[src/ars_pkg.sv]
// shared constants, codes and control types for the auto range scaler
`default_nettype none

package ars_pkg;

    // default sample width, signed Q1.22 at 24 bits
    localparam int SAMPLE_BITS_DEF = 24;

    // configuration port
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_USE_SIGNAL_BOUNDS = 2'd0,
        REG_OUT_LOW           = 2'd1,
        REG_OUT_HIGH          = 2'd2
    } t_reg_idx;

    // request action codes
    localparam int ACTION_BITS = 2;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_PRESET = 2'd2
    } t_action;

    // control into the multiply-divide unit
    typedef struct packed {
        logic start;
    } t_md_ctrl;

    // status out of the multiply-divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_md_stat;

endpackage

`default_nettype wire

[src/ars_in_if.sv]
// request channel: action, sample, per-request bounds and preset values
`default_nettype none

interface ars_in_if #(
    parameter int SAMPLE_BITS = ars_pkg::SAMPLE_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic [ars_pkg::ACTION_BITS-1:0]     action;
    logic signed [SAMPLE_BITS-1:0]       sample;
    logic signed [SAMPLE_BITS-1:0]       bound_low;
    logic signed [SAMPLE_BITS-1:0]       bound_high;
    logic signed [SAMPLE_BITS-1:0]       preset_min;
    logic signed [SAMPLE_BITS-1:0]       preset_max;

    modport source (
        output valid, action, sample, bound_low, bound_high, preset_min, preset_max,
        input  ready
    );

    modport sink (
        input  valid, action, sample, bound_low, bound_high, preset_min, preset_max,
        output ready
    );
endinterface

`default_nettype wire

[src/ars_out_if.sv]
// result channel: scaled sample and sorted tracked range
`default_nettype none

interface ars_out_if #(
    parameter int SAMPLE_BITS = ars_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] scaled;
    logic signed [SAMPLE_BITS-1:0] range_lower;
    logic signed [SAMPLE_BITS-1:0] range_upper;

    modport source (
        output valid, scaled, range_lower, range_upper,
        input  ready
    );

    modport sink (
        input  valid, scaled, range_lower, range_upper,
        output ready
    );
endinterface

`default_nettype wire

[src/auto_range_scaler.sv]
// auto range scaler top level: min/max tracking, bound selection and output mapping
//
//  channel   dir   handshake      contents
//  i_req     in    valid/ready    action, sample, bound_low/high, preset_min/max
//  o_res     out   valid/ready    scaled, range_lower, range_upper
//  i_cfg_*   in    write enable   use_signal_bounds, out_low, out_high
//
// A sample request goes from accept to the result register through setup,
// SAMPLE_BITS + 1 multiply-divide steps, done and hand-over. A zero input range
// skips the unit, going from setup to hand-over; clear and preset go straight to it.
// One request in flight; i_req.ready is high while idle, also while a result
// waits in o_res. A stalled result holds the block in its hand-over cycle.
// Reset is synchronous, active low, and clears tracking and configuration.
`default_nettype none

module auto_range_scaler #(
    parameter int SAMPLE_BITS = ars_pkg::SAMPLE_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [ars_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire  [SAMPLE_BITS-1:0]            i_cfg_data,
    ars_in_if.sink                            i_req,
    ars_out_if.source                         o_res
);

    localparam int MD_BITS  = SAMPLE_BITS + 1;
    localparam int SUM_BITS = SAMPLE_BITS + 2;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_HIGH_RESET =
        SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [SUM_BITS-1:0] SAT_TOP = SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_BOT = -SAT_TOP - SUM_BITS'(1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SETUP  = 4'b0010,
        ST_CALC   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic                          r_use_sb;
    logic signed [SAMPLE_BITS-1:0] r_out_low;
    logic signed [SAMPLE_BITS-1:0] r_out_high;

    // tracking state
    logic signed [SAMPLE_BITS-1:0] r_min, n_min;
    logic signed [SAMPLE_BITS-1:0] r_max, n_max;
    logic                          r_seeded, n_seeded;

    // per-request working registers
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic signed [SAMPLE_BITS-1:0] r_lo;
    logic signed [SAMPLE_BITS-1:0] r_hi;
    logic signed [SAMPLE_BITS-1:0] r_base;
    logic                          r_is_sample, n_is_sample;
    logic                          r_zero, n_zero;

    // result register
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_scaled;
    logic signed [SAMPLE_BITS-1:0] r_lower;
    logic signed [SAMPLE_BITS-1:0] r_upper;

    logic                          w_accept;
    logic                          w_seed;
    logic signed [SAMPLE_BITS-1:0] w_min0, w_max0;
    logic signed [SAMPLE_BITS-1:0] w_lo_sel, w_hi_sel;
    logic                          w_ordered;
    logic signed [MD_BITS-1:0]     w_ri_s, w_d_s, w_ro_s;
    logic [MD_BITS-1:0]            w_ri, w_d, w_ro;
    logic signed [SUM_BITS-1:0]    w_sum;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic                          w_load_out;
    ars_pkg::t_md_ctrl             w_md_ctrl;
    ars_pkg::t_md_stat             w_md_stat;
    logic [MD_BITS-1:0]            w_md_q;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_sb   <= 1'b0;
            r_out_low  <= '0;
            r_out_high <= OUT_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ars_pkg::REG_USE_SIGNAL_BOUNDS: r_use_sb   <= i_cfg_data[0];
                ars_pkg::REG_OUT_LOW:           r_out_low  <= i_cfg_data;
                ars_pkg::REG_OUT_HIGH:          r_out_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // seeding and extreme update on accept
    always_comb begin
        w_seed   = !r_seeded && (r_min == r_max);
        w_min0   = w_seed ? i_req.sample : r_min;
        w_max0   = w_seed ? i_req.sample : r_max;
        w_lo_sel = r_use_sb ? i_req.bound_low  : r_out_low;
        w_hi_sel = r_use_sb ? i_req.bound_high : r_out_high;
        n_min    = r_min;
        n_max    = r_max;
        n_seeded = r_seeded;
        if (w_accept) begin
            case (i_req.action)
                ars_pkg::ACT_SAMPLE: begin
                    n_seeded = r_seeded | w_seed;
                    n_min    = (i_req.sample < w_min0) ? i_req.sample : w_min0;
                    n_max    = (i_req.sample > w_max0) ? i_req.sample : w_max0;
                end
                ars_pkg::ACT_CLEAR: begin
                    n_min    = '0;
                    n_max    = '0;
                    n_seeded = 1'b0;
                end
                ars_pkg::ACT_PRESET: begin
                    n_min = i_req.preset_min;
                    n_max = i_req.preset_max;
                end
                default: begin
                end
            endcase
        end
    end

    // operand magnitudes; after a sample update min <= sample <= max
    always_comb begin
        w_ordered = (r_lo <= r_hi);
        w_ri_s    = MD_BITS'(r_max) - MD_BITS'(r_min);
        w_d_s     = w_ordered ? (MD_BITS'(r_smp) - MD_BITS'(r_min))
                              : (MD_BITS'(r_max) - MD_BITS'(r_smp));
        w_ro_s    = w_ordered ? (MD_BITS'(r_hi) - MD_BITS'(r_lo))
                              : (MD_BITS'(r_lo) - MD_BITS'(r_hi));
        w_ri      = w_ri_s;
        w_d       = w_d_s;
        w_ro      = w_ro_s;
    end

    assign w_md_ctrl.start = (r_state == ST_SETUP) && (w_ri != '0);

    ars_muldiv #(
        .MD_BITS (MD_BITS)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_md_ctrl),
        .i_d     (w_d),
        .i_ri    (w_ri),
        .i_ro    (w_ro),
        .o_stat  (w_md_stat),
        .o_q     (w_md_q)
    );

    // quotient plus base bound, saturated
    always_comb begin
        w_sum = (r_zero ? SUM_BITS'(0) : SUM_BITS'({1'b0, w_md_q})) + SUM_BITS'(r_base);
        if (w_sum > SAT_TOP) begin
            w_sat = SAT_TOP[SAMPLE_BITS-1:0];
        end else if (w_sum < SAT_BOT) begin
            w_sat = SAT_BOT[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_sum[SAMPLE_BITS-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_is_sample = r_is_sample;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;
        w_load_out  = 1'b0;
        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_is_sample = (i_req.action == ars_pkg::ACT_SAMPLE);
                    n_zero      = 1'b1;
                    n_state     = (i_req.action == ars_pkg::ACT_SAMPLE) ? ST_SETUP
                                                                       : ST_FINISH;
                end
            end
            ST_SETUP: begin
                n_zero  = (w_ri == '0);
                n_state = (w_ri == '0) ? ST_FINISH : ST_CALC;
            end
            ST_CALC: begin
                if (w_md_stat.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min       <= '0;
            r_max       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_is_sample <= 1'b0;
            r_zero      <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_min       <= n_min;
            r_max       <= n_max;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
            r_is_sample <= n_is_sample;
            r_zero      <= n_zero;
        end
    end

    // request payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smp  <= i_req.sample;
            r_lo   <= w_lo_sel;
            r_hi   <= w_hi_sel;
            r_base <= (w_lo_sel <= w_hi_sel) ? w_lo_sel : w_hi_sel;
        end
    end

    // result payload capture with sorted range
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_scaled <= r_is_sample ? w_sat : '0;
            r_lower  <= (r_min <= r_max) ? r_min : r_max;
            r_upper  <= (r_min <= r_max) ? r_max : r_min;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.scaled      = r_scaled;
    assign o_res.range_lower = r_lower;
    assign o_res.range_upper = r_upper;

endmodule

`default_nettype wire

[src/ars_muldiv.sv]
// iterative floor(d * ro / ri) unit, one multiplier bit per cycle, d <= ri
`default_nettype none

module ars_muldiv #(
    parameter int MD_BITS = ars_pkg::SAMPLE_BITS_DEF + 1
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire ars_pkg::t_md_ctrl i_ctrl,
    input  wire  [MD_BITS-1:0]     i_d,
    input  wire  [MD_BITS-1:0]     i_ri,
    input  wire  [MD_BITS-1:0]     i_ro,
    output ars_pkg::t_md_stat      o_stat,
    output logic [MD_BITS-1:0]     o_q
);

    localparam int CNT_BITS = (MD_BITS > 1) ? $clog2(MD_BITS) : 1;
    localparam int EXT_BITS = MD_BITS + 2;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt,  n_cnt;
    logic [MD_BITS-1:0]  r_b,    n_b;
    logic [MD_BITS-1:0]  r_ar,   n_ar;
    logic                r_aq,   n_aq;
    logic [MD_BITS-1:0]  r_c,    n_c;
    logic [MD_BITS-1:0]  r_q,    n_q;
    logic [MD_BITS-1:0]  r_rem,  n_rem;

    logic                w_bit;
    logic [EXT_BITS-1:0] w_r1;
    logic [EXT_BITS-1:0] w_b1;
    logic [EXT_BITS-1:0] w_b2;
    logic [EXT_BITS-1:0] w_sub;
    logic [1:0]          w_k;

    // one step: r = 2r + bit*ar, then reduce by 0, b or 2b
    always_comb begin
        w_bit = r_c[MD_BITS-1];
        w_r1  = {1'b0, r_rem, 1'b0} + {2'b00, (w_bit ? r_ar : {MD_BITS{1'b0}})};
        w_b1  = {2'b00, r_b};
        w_b2  = {1'b0, r_b, 1'b0};
        if (w_r1 >= w_b2) begin
            w_k   = 2'd2;
            w_sub = w_r1 - w_b2;
        end else if (w_r1 >= w_b1) begin
            w_k   = 2'd1;
            w_sub = w_r1 - w_b1;
        end else begin
            w_k   = 2'd0;
            w_sub = w_r1;
        end
    end

    // sequencer and datapath next state
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_b    = r_b;
        n_ar   = r_ar;
        n_aq   = r_aq;
        n_c    = r_c;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_ctrl.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_b    = i_ri;
            n_aq   = (i_d == i_ri);
            n_ar   = (i_d == i_ri) ? {MD_BITS{1'b0}} : i_d;
            n_c    = i_ro;
            n_q    = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_c   = {r_c[MD_BITS-2:0], 1'b0};
            n_q   = {r_q[MD_BITS-2:0], 1'b0} + MD_BITS'(w_bit & r_aq) + MD_BITS'(w_k);
            n_rem = w_sub[MD_BITS-1:0];
            n_cnt = r_cnt + CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(MD_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_b   <= n_b;
        r_ar  <= n_ar;
        r_aq  <= n_aq;
        r_c   <= n_c;
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_q         = r_q;

endmodule

`default_nettype wire
